/* hw/rtl/tmeu_pkg.sv */
// ----------------------------------------------------------------------------
// tmeu_pkg
// Opcodes, micro-operation encoding and the micro-program of the tape machine
// execute unit.
// ----------------------------------------------------------------------------
package tmeu_pkg;

  localparam int KIND_W = 5;
  localparam int STEP_W = 4;

  localparam logic [KIND_W-1:0] K_ADVANCE      = 5'd0;
  localparam logic [KIND_W-1:0] K_DECR1MX      = 5'd1;
  localparam logic [KIND_W-1:0] K_FALSEJUMP    = 5'd2;
  localparam logic [KIND_W-1:0] K_GIVE         = 5'd3;
  localparam logic [KIND_W-1:0] K_INCR         = 5'd4;
  localparam logic [KIND_W-1:0] K_INCR1MX      = 5'd5;
  localparam logic [KIND_W-1:0] K_M1ZERO       = 5'd6;
  localparam logic [KIND_W-1:0] K_MOVE         = 5'd7;
  localparam logic [KIND_W-1:0] K_MOVEWHILE    = 5'd8;
  localparam logic [KIND_W-1:0] K_MXDECR1      = 5'd9;
  localparam logic [KIND_W-1:0] K_MXINCR1      = 5'd10;
  localparam logic [KIND_W-1:0] K_OFFINCR      = 5'd11;
  localparam logic [KIND_W-1:0] K_PRINT        = 5'd12;
  localparam logic [KIND_W-1:0] K_READ         = 5'd13;
  localparam logic [KIND_W-1:0] K_TAKE         = 5'd14;
  localparam logic [KIND_W-1:0] K_TERMINATE    = 5'd15;
  localparam logic [KIND_W-1:0] K_TRUEJUMP     = 5'd16;
  localparam logic [KIND_W-1:0] K_VALUE        = 5'd17;
  localparam logic [KIND_W-1:0] K_WHILEDECROI2 = 5'd18;
  localparam logic [KIND_W-1:0] K_WHILEIM2     = 5'd19;
  localparam logic [KIND_W-1:0] K_WHILEIM3     = 5'd20;
  localparam logic [KIND_W-1:0] K_WHILEMGM     = 5'd21;
  localparam logic [KIND_W-1:0] K_ZERO         = 5'd22;
  localparam logic [KIND_W-1:0] K_ZERO2IF      = 5'd23;
  localparam logic [KIND_W-1:0] K_ZEROM1       = 5'd24;

  typedef enum logic [3:0] {
    A_NOP, A_RD, A_WR, A_MV, A_SAV, A_TEST, A_BR1, A_BRZ, A_BRNZ, A_PRINT, A_HALT
  } act_t;

  typedef enum logic [3:0] {
    S_ZERO, S_ONE, S_MONE, S_V, S_H0, S_H1, S_H2, S_H3, S_H4, S_H5
  } src_t;

  typedef enum logic [1:0] {D_ADD, D_SAV, D_ZERO, D_IN} dat_t;

  // flags: {long loop limit, last step, loop back}
  localparam logic [2:0] F_NONE = 3'b000;
  localparam logic [2:0] F_LNG  = 3'b100;
  localparam logic [2:0] F_LAST = 3'b010;
  localparam logic [2:0] F_LOOP = 3'b001;

  typedef struct packed {
    act_t       act;
    src_t       off;
    src_t       amt;
    dat_t       dat;
    logic       lng;
    logic       last;
    logic       loop;
  } uop_t;

  typedef struct packed {
    logic load;
    logic clr;
    logic rd;
    logic wr;
    logic mv;
    logic sav;
    logic push;
    src_t off;
    src_t amt;
    dat_t dat;
  } cmd_t;

  typedef struct packed {
    logic       zero;
    logic       clr_last;
    logic [7:0] rdata;
  } sts_t;

  function automatic uop_t u_wr(src_t o, src_t m, dat_t d, logic [2:0] f);
    uop_t r;
    r = '{act: A_WR, off: o, amt: m, dat: d, lng: f[2], last: f[1], loop: f[0]};
    return r;
  endfunction

  function automatic uop_t u_act(act_t a, src_t o, logic [2:0] f);
    uop_t r;
    r = '{act: a, off: o, amt: S_ZERO, dat: D_ADD, lng: f[2], last: f[1], loop: f[0]};
    return r;
  endfunction

  // Micro-program: one entry per step of each opcode.
  function automatic uop_t ucode(logic [KIND_W-1:0] kind, logic [STEP_W-1:0] step);
    uop_t r;
    r = u_act(A_NOP, S_ZERO, F_LAST);
    case (kind)
      K_ADVANCE: r = u_act(A_BR1, S_ZERO, F_LAST);
      K_DECR1MX, K_INCR1MX: begin
        case (step)
          4'd0:    r = u_act(A_RD, S_ZERO, F_NONE);
          4'd1:    r = u_wr(S_ZERO, (kind == K_DECR1MX) ? S_MONE : S_ONE, D_ADD, F_NONE);
          default: r = u_act(A_MV, S_V, F_LAST);
        endcase
      end
      K_FALSEJUMP, K_TRUEJUMP, K_PRINT: begin
        case (step)
          4'd0:    r = u_act(A_RD, S_ZERO, F_NONE);
          default: r = u_act((kind == K_FALSEJUMP) ? A_BRZ :
                             (kind == K_TRUEJUMP) ? A_BRNZ : A_PRINT, S_ZERO, F_LAST);
        endcase
      end
      K_GIVE: begin
        case (step)
          4'd0:    r = u_act(A_RD, S_ZERO, F_NONE);
          4'd1:    r = u_act(A_SAV, S_ZERO, F_NONE);
          4'd2:    r = u_act(A_RD, S_V, F_NONE);
          4'd3:    r = u_wr(S_V, S_ZERO, D_SAV, F_NONE);
          default: r = u_wr(S_ZERO, S_ZERO, D_ZERO, F_LAST);
        endcase
      end
      K_TAKE: begin
        case (step)
          4'd0:    r = u_act(A_RD, S_V, F_NONE);
          4'd1:    r = u_act(A_SAV, S_ZERO, F_NONE);
          4'd2:    r = u_act(A_RD, S_ZERO, F_NONE);
          4'd3:    r = u_wr(S_ZERO, S_ZERO, D_SAV, F_NONE);
          default: r = u_wr(S_V, S_ZERO, D_ZERO, F_LAST);
        endcase
      end
      K_INCR, K_OFFINCR: begin
        case (step)
          4'd0:    r = u_act(A_RD, (kind == K_INCR) ? S_ZERO : S_H0, F_NONE);
          default: r = u_wr((kind == K_INCR) ? S_ZERO : S_H0, S_V, D_ADD, F_LAST);
        endcase
      end
      K_M1ZERO: begin
        case (step)
          4'd0:    r = u_act(A_MV, S_ONE, F_NONE);
          default: r = u_wr(S_ZERO, S_ZERO, D_ZERO, F_LAST);
        endcase
      end
      K_ZEROM1: begin
        case (step)
          4'd0:    r = u_wr(S_ZERO, S_ZERO, D_ZERO, F_NONE);
          default: r = u_act(A_MV, S_ONE, F_LAST);
        endcase
      end
      K_MOVE:      r = u_act(A_MV, S_V, F_LAST);
      K_READ:      r = u_wr(S_ZERO, S_ZERO, D_IN, F_LAST);
      K_ZERO:      r = u_wr(S_ZERO, S_ZERO, D_ZERO, F_LAST);
      K_TERMINATE: r = u_act(A_HALT, S_ZERO, F_LAST);
      K_MOVEWHILE: begin
        case (step)
          4'd0:    r = u_act(A_RD, S_ZERO, F_NONE);
          4'd1:    r = u_act(A_TEST, S_ZERO, F_NONE);
          default: r = u_act(A_MV, S_V, F_LOOP);
        endcase
      end
      K_MXDECR1, K_MXINCR1: begin
        case (step)
          4'd0:    r = u_act(A_RD, S_V, F_NONE);
          4'd1:    r = u_wr(S_V, (kind == K_MXDECR1) ? S_MONE : S_ONE, D_ADD, F_NONE);
          default: r = u_act(A_MV, S_V, F_LAST);
        endcase
      end
      K_WHILEDECROI2: begin
        case (step)
          4'd0:    r = u_act(A_RD, S_ZERO, F_NONE);
          4'd1:    r = u_act(A_TEST, S_ZERO, F_LNG);
          4'd2:    r = u_wr(S_ZERO, S_MONE, D_ADD, F_NONE);
          4'd3:    r = u_act(A_RD, S_H1, F_NONE);
          4'd4:    r = u_wr(S_H1, S_ONE, D_ADD, F_NONE);
          4'd5:    r = u_act(A_RD, S_H0, F_NONE);
          default: r = u_wr(S_H0, S_ONE, D_ADD, F_LOOP);
        endcase
      end
      K_WHILEIM2: begin
        case (step)
          4'd0:    r = u_act(A_RD, S_ZERO, F_NONE);
          4'd1:    r = u_act(A_TEST, S_ZERO, F_LNG);
          4'd2:    r = u_wr(S_ZERO, S_H3, D_ADD, F_NONE);
          4'd3:    r = u_act(A_MV, S_H2, F_NONE);
          4'd4:    r = u_act(A_RD, S_ZERO, F_NONE);
          4'd5:    r = u_wr(S_ZERO, S_H1, D_ADD, F_NONE);
          default: r = u_act(A_MV, S_H0, F_LOOP);
        endcase
      end
      K_WHILEIM3: begin
        case (step)
          4'd0:    r = u_act(A_RD, S_ZERO, F_NONE);
          4'd1:    r = u_act(A_TEST, S_ZERO, F_LNG);
          4'd2:    r = u_wr(S_ZERO, S_H5, D_ADD, F_NONE);
          4'd3:    r = u_act(A_MV, S_H4, F_NONE);
          4'd4:    r = u_act(A_RD, S_ZERO, F_NONE);
          4'd5:    r = u_wr(S_ZERO, S_H3, D_ADD, F_NONE);
          4'd6:    r = u_act(A_MV, S_H2, F_NONE);
          4'd7:    r = u_act(A_RD, S_ZERO, F_NONE);
          4'd8:    r = u_wr(S_ZERO, S_H1, D_ADD, F_NONE);
          default: r = u_act(A_MV, S_H0, F_LOOP);
        endcase
      end
      K_WHILEMGM: begin
        case (step)
          4'd0:    r = u_act(A_RD, S_ZERO, F_NONE);
          4'd1:    r = u_act(A_TEST, S_ZERO, F_LNG);
          4'd2:    r = u_act(A_MV, S_H1, F_NONE);
          4'd3:    r = u_act(A_RD, S_ZERO, F_NONE);
          4'd4:    r = u_act(A_SAV, S_ZERO, F_NONE);
          4'd5:    r = u_act(A_RD, S_H0, F_NONE);
          4'd6:    r = u_wr(S_H0, S_ZERO, D_SAV, F_NONE);
          4'd7:    r = u_wr(S_ZERO, S_ZERO, D_ZERO, F_NONE);
          default: r = u_act(A_MV, S_V, F_LOOP);
        endcase
      end
      K_ZERO2IF: begin
        case (step)
          4'd0:    r = u_act(A_RD, S_ZERO, F_NONE);
          4'd1:    r = u_act(A_TEST, S_ZERO, F_NONE);
          4'd2:    r = u_wr(S_ZERO, S_ZERO, D_ZERO, F_NONE);
          default: r = u_wr(S_ONE, S_ZERO, D_ZERO, F_LAST);
        endcase
      end
      default: r = u_act(A_NOP, S_ZERO, F_LAST);
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/tape_machine_execute_unit.sv */
// ----------------------------------------------------------------------------
// tape_machine_execute_unit
// Executes one byte-tape machine instruction per transfer and returns one
// result transfer per instruction.
// ----------------------------------------------------------------------------
// After reset the unit sweeps the tape to zero, one cell per cycle
// (TAPE_CELLS must be a power of two); in_tready stays low meanwhile. It
// then works on one instruction at a time. A micro-sequencer steps through
// the micro-steps of each opcode; the tape memory has one write port and one
// registered read port, and each tape read or write is a micro-step of its
// own. The while ops repeat their steps once per pass until the tested cell
// is zero or the loop limit is hit. A halted unit answers each item without
// running its micro-program. The result sits in an output register, so the
// next item is taken while the previous result waits.
// ----------------------------------------------------------------------------
module tape_machine_execute_unit #(
  parameter int TAPE_CELLS   = 32768,
  parameter int OPERAND_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // kind[4:0], operand[20:5], in_byte[28:21], in_eof[29], zero pad
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // branch_taken[0], out_byte[8:1], out_valid[9], halted[10], zero pad
  output logic [15:0] out_tdata
);
  import tmeu_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic        done, res_br, res_print, res_halt, out_free;
  logic        out_tvalid_r;
  logic [15:0] out_tdata_r;
  logic [7:0]  res_byte;

  // output register frees when empty or when its transfer completes
  assign out_free = !out_tvalid_r || out_tready;

  tmeu_ctrl #(
    .TAPE_CELLS(TAPE_CELLS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_kind   (in_tdata[4:0]),
    .out_free  (out_free),
    .sts       (sts),
    .cmd       (cmd),
    .done      (done),
    .res_br    (res_br),
    .res_print (res_print),
    .res_halt  (res_halt)
  );

  tmeu_dpath #(
    .TAPE_CELLS  (TAPE_CELLS),
    .OPERAND_BITS(OPERAND_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_operand(in_tdata[20:5]),
    .in_byte   (in_tdata[28:21]),
    .in_eof    (in_tdata[29]),
    .sts       (sts)
  );

  // printed byte is the last cell read; zero for every other op
  assign res_byte = res_print ? sts.rdata : 8'd0;

  always_ff @(posedge clk) begin
    if (done)
      out_tdata_r <= {5'd0, res_halt, res_print, res_byte, res_br};
    if (!rst_n)
      out_tvalid_r <= 1'b0;
    else if (done)
      out_tvalid_r <= 1'b1;
    else if (out_tready)
      out_tvalid_r <= 1'b0;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

/* hw/rtl/tmeu_ctrl.sv */
// ----------------------------------------------------------------------------
// tmeu_ctrl
// Micro-sequencer: walks the micro-program of the current opcode, counts loop
// iterations and collects the result flags.
// ----------------------------------------------------------------------------
module tmeu_ctrl #(
  parameter int TAPE_CELLS = 32768
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [tmeu_pkg::KIND_W-1:0] in_kind,
  input  logic                        out_free,
  input  tmeu_pkg::sts_t              sts,
  output tmeu_pkg::cmd_t              cmd,
  output logic                        done,
  output logic                        res_br,
  output logic                        res_print,
  output logic                        res_halt
);
  import tmeu_pkg::*;

  localparam int CNT_W = $clog2(TAPE_CELLS) + 9;
  localparam logic [CNT_W-1:0] LIM_M = CNT_W'(TAPE_CELLS);
  localparam logic [CNT_W-1:0] LIM_L = CNT_W'(TAPE_CELLS * 256);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_RUN, ST_DONE} state_t;

  state_t              state_r;
  logic [STEP_W-1:0]   step_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [KIND_W-1:0]   kind_r;
  logic                halt_r, br_r, prn_r;
  uop_t                uop;
  logic                run, hit, fin, accept;

  assign uop       = ucode(kind_r, step_r);
  assign run       = (state_r == ST_RUN);
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign hit       = uop.lng ? (cnt_r == LIM_L) : (cnt_r == LIM_M);
  assign fin       = uop.last || ((uop.act == A_TEST) && (sts.zero || hit));
  assign done      = (state_r == ST_DONE) && out_free;
  assign res_br    = br_r;
  assign res_print = prn_r;
  assign res_halt  = halt_r;

  always_comb begin
    cmd      = '0;
    cmd.off  = uop.off;
    cmd.amt  = uop.amt;
    cmd.dat  = uop.dat;
    cmd.load = accept;
    cmd.clr  = (state_r == ST_CLEAR);
    cmd.rd   = run && (uop.act == A_RD);
    cmd.wr   = run && (uop.act == A_WR);
    cmd.mv   = run && (uop.act == A_MV);
    cmd.sav  = run && (uop.act == A_SAV);
    cmd.push = run && fin;
  end

  always_ff @(posedge clk) begin
    if (accept)
      kind_r <= in_kind;
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      step_r  <= '0;
      cnt_r   <= '0;
      halt_r  <= 1'b0;
      br_r    <= 1'b0;
      prn_r   <= 1'b0;
    end else begin
      case (state_r)
        ST_CLEAR: begin
          if (sts.clr_last)
            state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            step_r  <= '0;
            cnt_r   <= '0;
            br_r    <= 1'b0;
            prn_r   <= 1'b0;
            state_r <= halt_r ? ST_DONE : ST_RUN;
          end
        end
        ST_RUN: begin
          case (uop.act)
            A_BR1:   br_r   <= 1'b1;
            A_BRZ:   br_r   <= sts.zero;
            A_BRNZ:  br_r   <= !sts.zero;
            A_PRINT: prn_r  <= 1'b1;
            A_HALT:  halt_r <= 1'b1;
            A_TEST:  cnt_r  <= cnt_r + 1'b1;
            default: ;
          endcase
          if (fin)
            state_r <= ST_DONE;
          else if (uop.loop)
            step_r <= '0;
          else
            step_r <= step_r + 1'b1;
        end
        ST_DONE: begin
          if (out_free)
            state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/tmeu_dpath.sv */
// ----------------------------------------------------------------------------
// tmeu_dpath
// Tape memory, data pointer, operand history and the cell adder.
// ----------------------------------------------------------------------------
module tmeu_dpath #(
  parameter int TAPE_CELLS   = 32768,
  parameter int OPERAND_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tmeu_pkg::cmd_t cmd,
  input  logic [15:0]    in_operand,
  input  logic [7:0]     in_byte,
  input  logic           in_eof,
  output tmeu_pkg::sts_t sts
);
  import tmeu_pkg::*;

  localparam int PTR_W = $clog2(TAPE_CELLS);
  localparam int HIST  = 6;

  logic [7:0]                     tape_r [TAPE_CELLS];
  logic [PTR_W-1:0]               dp_r, clr_addr_r, addr;
  logic signed [OPERAND_BITS-1:0] hist_r [HIST];
  logic signed [OPERAND_BITS-1:0] op_r, off_v, amt_v;
  logic [7:0]                     sav_r, rdata_r, ib_r, wdata;
  logic                           eof_r, we;

  function automatic logic signed [OPERAND_BITS-1:0] pick(src_t s);
    logic signed [OPERAND_BITS-1:0] r;
    case (s)
      S_ONE:   r = OPERAND_BITS'(1);
      S_MONE:  r = '1;
      S_V:     r = op_r;
      S_H0:    r = hist_r[0];
      S_H1:    r = hist_r[1];
      S_H2:    r = hist_r[2];
      S_H3:    r = hist_r[3];
      S_H4:    r = hist_r[4];
      S_H5:    r = hist_r[5];
      default: r = '0;
    endcase
    return r;
  endfunction

  always_comb begin
    off_v = pick(cmd.off);
    amt_v = pick(cmd.amt);
    addr  = dp_r + PTR_W'(off_v);
    case (cmd.dat)
      D_ADD:   wdata = rdata_r + amt_v[7:0];
      D_SAV:   wdata = rdata_r + sav_r;
      D_IN:    wdata = ib_r;
      default: wdata = '0;
    endcase
    we = cmd.wr && !((cmd.dat == D_IN) && eof_r);
  end

  // tape: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clr)
      tape_r[clr_addr_r] <= '0;
    else if (we)
      tape_r[addr] <= wdata;
    if (cmd.rd)
      rdata_r <= tape_r[addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= OPERAND_BITS'(in_operand);
      ib_r  <= in_byte;
      eof_r <= in_eof;
    end
    if (cmd.sav)
      sav_r <= rdata_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dp_r       <= '0;
      clr_addr_r <= '0;
      for (int i = 0; i < HIST; i++)
        hist_r[i] <= '0;
    end else begin
      if (cmd.clr)
        clr_addr_r <= clr_addr_r + 1'b1;
      if (cmd.mv)
        dp_r <= addr;
      if (cmd.push) begin
        for (int i = HIST - 1; i > 0; i--)
          hist_r[i] <= hist_r[i-1];
        hist_r[0] <= op_r;
      end
    end
  end

  assign sts.zero     = (rdata_r == 8'd0);
  assign sts.clr_last = (clr_addr_r == '1);
  assign sts.rdata    = rdata_r;

endmodule

/* test/tape_machine_execute_unit_chk.sv */
// ----------------------------------------------------------------------------
// tape_machine_execute_unit_chk
// Watches both channels of the execute unit, runs its own copy of the tape
// machine on every accepted instruction and compares each result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tape_machine_execute_unit_chk (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  output int          n_issued,
  output int          n_retired,
  output int          n_errors
);
  import tmeu_pkg::*;

  localparam int CELLS      = 32768;
  localparam int LOOP_LIMIT = CELLS * 256;

  typedef struct packed {
    logic       halted;
    logic       printed;
    logic [7:0] pbyte;
    logic       branch;
  } outcome_t;

  bit [7:0]    tape [0:CELLS-1];
  bit [14:0]   ptr;
  logic [15:0] hist [0:5];
  bit          stopped;
  outcome_t    due_q [$];
  int          issued_i, retired_i, errors_i;

  function automatic bit [14:0] cell_at(logic [15:0] off);
    return ptr + off[14:0];
  endfunction

  function automatic void bump(logic [15:0] off, logic [15:0] amt);
    bit [14:0] i;
    i = cell_at(off);
    tape[i] = tape[i] + amt[7:0];
  endfunction

  // append one expected result at the tail
  function automatic void queue_due(outcome_t o);
    due_q.insert(due_q.size(), o);
  endfunction

  // one instruction through the shadow machine
  function automatic outcome_t run_instr(logic [4:0] kind, logic [15:0] v, logic [7:0] ib,
                                         logic eof);
    outcome_t  r;
    bit [7:0]  c;
    bit [14:0] i;
    int        n;
    r = '0;
    if (stopped) begin
      r.halted = 1'b1;
      return r;
    end
    case (kind)
      K_ADVANCE:   r.branch = 1'b1;
      K_DECR1MX:   begin bump(16'd0, 16'hFFFF); ptr = cell_at(v); end
      K_FALSEJUMP: r.branch = (tape[ptr] == 0);
      K_GIVE: begin
        c = tape[ptr];
        bump(v, {8'h00, c});
        tape[ptr] = 0;
      end
      K_INCR:      bump(16'd0, v);
      K_INCR1MX:   begin bump(16'd0, 16'd1); ptr = cell_at(v); end
      K_M1ZERO:    begin ptr = cell_at(16'd1); tape[ptr] = 0; end
      K_MOVE:      ptr = cell_at(v);
      K_MOVEWHILE: begin
        for (n = 0; tape[ptr] != 0 && n < CELLS; n++) ptr = cell_at(v);
      end
      K_MXDECR1:   begin ptr = cell_at(v); bump(16'd0, 16'hFFFF); end
      K_MXINCR1:   begin ptr = cell_at(v); bump(16'd0, 16'd1); end
      K_OFFINCR:   bump(hist[0], v);
      K_PRINT:     begin r.pbyte = tape[ptr]; r.printed = 1'b1; end
      K_READ:      if (!eof) tape[ptr] = ib;
      K_TAKE: begin
        i = cell_at(v);
        bump(16'd0, {8'h00, tape[i]});
        tape[i] = 0;
      end
      K_TERMINATE: stopped = 1'b1;
      K_TRUEJUMP:  r.branch = (tape[ptr] != 0);
      K_WHILEDECROI2: begin
        for (n = 0; tape[ptr] != 0 && n < LOOP_LIMIT; n++) begin
          bump(16'd0, 16'hFFFF); bump(hist[1], 16'd1); bump(hist[0], 16'd1);
        end
      end
      K_WHILEIM2: begin
        for (n = 0; tape[ptr] != 0 && n < LOOP_LIMIT; n++) begin
          bump(16'd0, hist[3]); ptr = cell_at(hist[2]);
          bump(16'd0, hist[1]); ptr = cell_at(hist[0]);
        end
      end
      K_WHILEIM3: begin
        for (n = 0; tape[ptr] != 0 && n < LOOP_LIMIT; n++) begin
          bump(16'd0, hist[5]); ptr = cell_at(hist[4]);
          bump(16'd0, hist[3]); ptr = cell_at(hist[2]);
          bump(16'd0, hist[1]); ptr = cell_at(hist[0]);
        end
      end
      K_WHILEMGM: begin
        for (n = 0; tape[ptr] != 0 && n < LOOP_LIMIT; n++) begin
          ptr = cell_at(hist[1]);
          c = tape[ptr];
          bump(hist[0], {8'h00, c});
          tape[ptr] = 0;
          ptr = cell_at(v);
        end
      end
      K_ZERO:      tape[ptr] = 0;
      K_ZERO2IF: begin
        if (tape[ptr] != 0) begin
          tape[ptr] = 0;
          tape[cell_at(16'd1)] = 0;
        end
      end
      K_ZEROM1:    begin tape[ptr] = 0; ptr = cell_at(16'd1); end
      default: ;
    endcase
    for (n = 5; n > 0; n--) hist[n] = hist[n-1];
    hist[0] = v;
    r.halted = stopped;
    return r;
  endfunction

  always @(posedge clk) begin
    outcome_t want, got;
    if (!rst_n) begin
      for (int k = 0; k < CELLS; k++) tape[k] = 0;
      for (int k = 0; k < 6; k++) hist[k] = '0;
      ptr = 0;
      stopped = 0;
      due_q.delete();
      issued_i = 0;
      retired_i = 0;
      errors_i = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[10:0];
        retired_i++;
        if (due_q.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none, actual %h", $time, got);
          errors_i++;
        end else begin
          want = due_q.pop_front();
          if (got.branch !== want.branch || got.pbyte !== want.pbyte ||
              got.printed !== want.printed || got.halted !== want.halted ||
              out_tdata[15:11] !== 5'd0) begin
            $display("%0t: result mismatch, expected br=%b byte=%h pv=%b halt=%b,",
                     $time, want.branch, want.pbyte, want.printed, want.halted);
            $display("    actual br=%b byte=%h pv=%b halt=%b pad=%b",
                     got.branch, got.pbyte, got.printed, got.halted, out_tdata[15:11]);
            errors_i++;
          end
        end
      end
      // the instruction transfer is predicted after the result check: a fresh
      // result cannot appear in the cycle its instruction goes in
      if (in_tvalid && in_tready) begin
        queue_due(run_instr(in_tdata[4:0], in_tdata[20:5], in_tdata[28:21], in_tdata[29]));
        issued_i++;
      end
    end
    n_issued  <= issued_i;
    n_retired <= retired_i;
    n_errors  <= errors_i;
  end

endmodule

/* test/tape_machine_execute_unit_tb.sv */
// ----------------------------------------------------------------------------
// tape_machine_execute_unit_tb
// Drives instruction streams into the execute unit: a directed opening over
// most opcodes and edge values, then random well-formed loop set-ups mixed with
// noise, under bursty input and a stalling result side. The checker compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tape_machine_execute_unit_tb;
  import tmeu_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;    // kind[4:0], operand[20:5], in_byte[28:21], in_eof[29]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // branch_taken[0], out_byte[8:1], out_valid[9], halted[10]

  int n_issued, n_retired, n_errors;
  int sent       = 0;
  int burst_left = 0;
  bit gappy      = 1'b1;
  int hold_reqs  = 0;            // bumped by the stimulus to ask for a long stall
  int loop_seqs  = 0;

  tape_machine_execute_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  tape_machine_execute_unit_chk chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .n_issued(n_issued), .n_retired(n_retired), .n_errors(n_errors)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // watchdog: the tape clear plus one full-length pointer sweep fit many times over
  initial begin
    #20000000;
    $display("tape_machine_execute_unit_tb NOT OK");
    $finish;
  end

  // result side: changing stall pattern, plus a long hold-off on request
  initial begin
    int mode, seg, hold, seen;
    mode = 0; seg = 0; hold = 0; seen = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != seen) begin
        seen = hold_reqs;
        hold = 300;
      end
      if (seg == 0) begin
        mode = $urandom_range(0, 3);
        seg  = $urandom_range(100, 600);
      end
      seg--;
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= ($urandom_range(0, 7) != 0);
          default: out_tready <= ((seg % 5) < 3);
        endcase
      end
    end
  end

  // one instruction transfer; valid stays up inside a burst
  task automatic issue(logic [4:0] kind, logic [15:0] op, logic [7:0] b = 8'h00,
                       logic eof = 1'b0);
    if (burst_left == 0) begin
      if (gappy) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, eof, b, op, kind};
    do @(posedge clk); while (!in_tready);
    burst_left--;
    sent++;
  endtask

  function automatic logic [15:0] near();
    return 16'($signed($urandom_range(0, 40)) - 20);
  endfunction

  function automatic logic [15:0] near_nz();
    logic [15:0] x;
    x = near();
    return (x == 0) ? 16'd3 : x;
  endfunction

  function automatic logic [15:0] odd_step();
    return near() | 16'd1;
  endfunction

  // a random operand: mostly small offsets, sometimes any 16-bit value
  function automatic logic [15:0] any_op();
    return ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) : near();
  endfunction

  // noise: any opcode bar TERMINATE and the loops, whose bounds are unknown on a random tape
  task automatic noise();
    logic [4:0] k;
    k = 5'($urandom_range(0, 31));
    if (k == K_MOVEWHILE || (k >= K_WHILEDECROI2 && k <= K_WHILEMGM) || k == K_TERMINATE)
      k = K_VALUE;
    issue(k, any_op(), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // set-ups whose loops end after a short, bounded number of passes
  task automatic loop_setup();
    logic [15:0] a, b, d, st;
    loop_seqs++;
    case ($urandom_range(0, 5))
      0: begin
        // scan: plant a zero a few strides away
        st = near_nz();
        d  = st * 16'($urandom_range(1, 6));
        issue(K_MOVE, d); issue(K_ZERO, near()); issue(K_MOVE, -d);
        issue(K_MOVEWHILE, st);
      end
      1: begin
        if ($urandom_range(0, 1)) issue(K_ZERO, near());
        issue(K_INCR, 16'($urandom_range(1, 12)));
        issue(K_VALUE, near_nz()); issue(K_VALUE, near_nz());
        issue(K_WHILEDECROI2, any_op());
      end
      2: begin
        // odd step on the home cell always reaches zero
        b = near_nz();
        issue(K_INCR, any_op());
        issue(K_VALUE, odd_step()); issue(K_VALUE, b); issue(K_VALUE, near());
        issue(K_VALUE, -b);
        issue(K_WHILEIM2, any_op());
      end
      3: begin
        b = near_nz();
        d = near_nz();
        if (b + d == 0) d = d + 16'd1;
        if (d == 0) d = 16'd1;
        issue(K_INCR, any_op());
        issue(K_VALUE, odd_step()); issue(K_VALUE, b); issue(K_VALUE, near());
        issue(K_VALUE, d); issue(K_VALUE, near()); issue(K_VALUE, -(b + d));
        issue(K_WHILEIM3, any_op());
      end
      4: begin
        // return stride zero: the emptied cell ends the loop after one pass
        issue(K_INCR, any_op());
        issue(K_VALUE, near_nz()); issue(K_VALUE, near());
        issue(K_WHILEMGM, 16'd0);
      end
      default: begin
        a = near();
        issue(K_VALUE, a); issue(K_OFFINCR, any_op());
        issue($urandom_range(0, 1) ? K_TRUEJUMP : K_FALSEJUMP, any_op());
        issue(K_PRINT, near());
      end
    endcase
  endtask

  // one edge first so the checker's counts include the last transfer
  task automatic drain();
    @(posedge clk);
    while (n_issued != n_retired) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    int mark;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed opening: edge operands, wrap, aliasing, end of input, spare opcodes
    issue(K_ADVANCE, 16'h7FFF);
    issue(K_MOVE, 16'hFFFF);                 // pointer wraps below zero
    issue(K_INCR, 16'h8000);                 // low byte zero
    issue(K_INCR, 16'h00FF);
    issue(K_PRINT, 16'h0000);
    issue(K_READ, 16'h0000, 8'hA5, 1'b0);
    issue(K_READ, 16'h0000, 8'hFF, 1'b1);    // end of input leaves the cell alone
    issue(K_PRINT, 16'h7FFF);
    issue(K_FALSEJUMP, 16'h8000);
    issue(K_TRUEJUMP, 16'h7FFF);
    issue(K_GIVE, 16'h0000);                 // give to itself clears the cell
    issue(K_INCR, 16'd7);
    issue(K_TAKE, 16'h0000);
    issue(K_INCR, 16'd9);
    issue(K_GIVE, 16'd3);
    issue(K_TAKE, 16'd3);
    issue(K_DECR1MX, 16'd5);
    issue(K_INCR1MX, 16'hFFFB);
    issue(K_MXDECR1, 16'd2);
    issue(K_MXINCR1, 16'hFFFE);
    issue(K_M1ZERO, 16'h0000);
    issue(K_ZEROM1, 16'h0000);
    issue(K_ZERO2IF, 16'h0000);
    for (int k = 25; k < 32; k++) issue(5'(k), 16'($urandom_range(0, 65535)));
    issue(K_OFFINCR, 16'd4);
    // runaway scan: stride zero on a live cell stops after a full tape of steps
    issue(K_INCR, 16'd1);
    issue(K_MOVEWHILE, 16'h0000);
    issue(K_ZERO, 16'h0000);

    // random part
    mark = 0;
    while (sent < 940) begin
      if (sent - mark > 120) begin
        mark  = sent;
        gappy = $urandom_range(0, 2) != 0;
        case ($urandom_range(0, 2))
          0: hold_reqs++;                    // long result stall, input keeps offering
          1: begin in_tvalid <= 1'b0; burst_left = 0; drain(); end
          default: ;
        endcase
      end
      if ($urandom_range(0, 2) == 0) loop_setup();
      else noise();
    end
    // make sure both pressure cases happened at least once
    hold_reqs++;
    repeat (4) noise();
    in_tvalid <= 1'b0;
    burst_left = 0;
    drain();

    // halt, then everything is ignored
    issue(K_TERMINATE, near());
    for (int k = 0; k < 8; k++) issue(5'($urandom_range(0, 31)), any_op(), 8'hC3, 1'b0);
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (n_issued != n_retired) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("Summary: %0d instructions issued, %0d loop set-ups, %0d results compared",
             n_issued, loop_seqs, n_retired);
    $display("Run covered all opcodes, spare opcodes, halt, long stalls and a full drain");
    if (n_errors == 0) begin
      $display("tape_machine_execute_unit_tb OK");
    end else begin
      $display("tape_machine_execute_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/tmeu_pkg.sv
hw/rtl/tmeu_ctrl.sv
hw/rtl/tmeu_dpath.sv
hw/rtl/tape_machine_execute_unit.sv
test/tape_machine_execute_unit_chk.sv
test/tape_machine_execute_unit_tb.sv
